>>> rtl/rlsd_pkg.sv
// ----------------------------------------------------------------------------
// rlsd_pkg
// Types, constants and tables shared by the ring line sensor direction block.
// ----------------------------------------------------------------------------
package rlsd_pkg;

   localparam int INNER_SENSORS = 24;
   localparam int SENSOR_W      = 30;
   localparam int OUTER_W       = 4;
   localparam int IDX_W         = $clog2(INNER_SENSORS);
   localparam int STEP_W        = $clog2(INNER_SENSORS + 1);
   localparam int UV_W          = 14;
   localparam int ACC_W         = 18;
   localparam int DIV_W         = 18;
   localparam int RC_W          = 5;
   localparam int RUNS_W        = 4;
   localparam int CX_W          = 24;
   localparam int CZ_W          = 18;
   localparam int ITER_W        = 4;
   localparam int CORDIC_STEPS  = 15;
   localparam int GAIN_W        = 16;
   localparam int PROD_W        = CX_W - 1 + GAIN_W;
   localparam int ANG_W         = 16;
   localparam int CSR_IDX_W     = 2;
   localparam int CSR_DATA_W    = 32;

   localparam logic [GAIN_W-1:0]     LEN_GAIN   = 16'd39797;
   localparam logic [ACC_W-1:0]      Q12_ONE    = 18'd4096;
   localparam logic [SENSOR_W-1:0]   MASK_RESET = 30'd4;
   localparam logic [ANG_W-1:0]      GATE_RESET = 16'd4096;
   localparam logic [CSR_IDX_W-1:0]  REG_MASK   = 2'd0;
   localparam logic [CSR_IDX_W-1:0]  REG_GATE   = 2'd1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DIV_X,
      ST_DIV_Y,
      ST_VEC_INIT,
      ST_VEC,
      ST_MUL,
      ST_LEN,
      ST_DIST,
      ST_DIV_D,
      ST_FIN
   } state_type;

   function automatic logic [13:0] atan_unit(input logic [ITER_W-1:0] i);
      logic [13:0] r;
      unique case (i)
         4'd0:    r = 14'd8192;
         4'd1:    r = 14'd4836;
         4'd2:    r = 14'd2555;
         4'd3:    r = 14'd1297;
         4'd4:    r = 14'd651;
         4'd5:    r = 14'd326;
         4'd6:    r = 14'd163;
         4'd7:    r = 14'd81;
         4'd8:    r = 14'd41;
         4'd9:    r = 14'd20;
         4'd10:   r = 14'd10;
         4'd11:   r = 14'd5;
         4'd12:   r = 14'd3;
         4'd13:   r = 14'd1;
         4'd14:   r = 14'd1;
         default: r = 14'd0;
      endcase
      return r;
   endfunction

   // Q12 unit vectors of the inner sensors, rotation-mode CORDIC at elaboration
   function automatic logic [INNER_SENSORS*UV_W-1:0] unit_table(input logic want_y);
      logic [INNER_SENSORS*UV_W-1:0] t;
      longint z, x, y, nx;
      logic   flip;
      t = '0;
      for (int k = 0; k < INNER_SENSORS; k++) begin
         z = (longint'(k) * 65536) / INNER_SENSORS;
         x = 39797;
         y = 0;
         flip = 1'b0;
         if (z >= 32768) z = z - 65536;
         if (z > 16384) begin
            z = z - 32768;
            flip = 1'b1;
         end else if (z < -16384) begin
            z = z + 32768;
            flip = 1'b1;
         end
         for (int i = 0; i < CORDIC_STEPS; i++) begin
            if (z >= 0) begin
               nx = x - (y >>> i);
               y  = y + (x >>> i);
               z  = z - longint'(atan_unit(ITER_W'(i)));
            end else begin
               nx = x + (y >>> i);
               y  = y - (x >>> i);
               z  = z + longint'(atan_unit(ITER_W'(i)));
            end
            x = nx;
         end
         x = (x + 8) >>> 4;
         y = (y + 8) >>> 4;
         if (flip) begin
            x = -x;
            y = -y;
         end
         t[k*UV_W +: UV_W] = want_y ? y[UV_W-1:0] : x[UV_W-1:0];
      end
      return t;
   endfunction

   localparam logic [INNER_SENSORS*UV_W-1:0] UX_TABLE = unit_table(1'b0);
   localparam logic [INNER_SENSORS*UV_W-1:0] UY_TABLE = unit_table(1'b1);

endpackage

>>> rtl/rlsd_if.sv
// ----------------------------------------------------------------------------
// rlsd channel interfaces
// Frame input, result output and register write channels.
// ----------------------------------------------------------------------------
interface rlsd_req_if;
   logic                          valid;
   logic                          ready;
   logic [rlsd_pkg::SENSOR_W-1:0] sensor_bits;
   modport source (output valid, output sensor_bits, input ready);
   modport sink   (input valid, input sensor_bits, output ready);
endinterface

interface rlsd_rsp_if;
   logic              valid;
   logic              ready;
   logic              contact;
   logic [4:0]        inner_active_count;
   logic [3:0]        outer_flags;
   logic [3:0]        run_count;
   logic signed [15:0] direction;
   logic [15:0]       distance;
   modport source (output valid, output contact, output inner_active_count,
                   output outer_flags, output run_count, output direction,
                   output distance, input ready);
   modport sink   (input valid, input contact, input inner_active_count,
                   input outer_flags, input run_count, input direction,
                   input distance, output ready);
endinterface

interface rlsd_csr_if;
   logic                            valid;
   logic                            ready;
   logic [rlsd_pkg::CSR_IDX_W-1:0]  index;
   logic [rlsd_pkg::CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/ring_line_sensor_direction_unit.sv
// ----------------------------------------------------------------------------
// ring_line_sensor_direction_unit
// Ring line sensor frame to gated direction and distance.
// ----------------------------------------------------------------------------
// channel | dir | payload
// req_ch  | in  | sensor_bits
// rsp_ch  | out | contact, inner_active_count, outer_flags, run_count,
//         |     | direction, distance
// csr_ch  | in  | index, data (0 disabled mask, 1 gate half width)
//
// One frame at a time, accept to accept. Frames without contact go straight to
// the result and outer-only frames skip the scan. Each run takes two divides
// and the distance one more, on the shared restoring divider; the 15-step
// CORDIC loop is skipped when the run means cancel to zero.
// Synchronous reset clears control state and restores register defaults.
// A stalled rsp_ch holds the finished transaction; req_ch waits until idle.
// ----------------------------------------------------------------------------
module ring_line_sensor_direction_unit (
   input logic          clock,
   input logic          reset,
   rlsd_req_if.sink     req_ch,
   rlsd_rsp_if.source   rsp_ch,
   rlsd_csr_if.sink     csr_ch
);
   localparam int N = rlsd_pkg::INNER_SENSORS;

   rlsd_pkg::state_type state_ff, state_in;

   logic [rlsd_pkg::SENSOR_W-1:0]   mask_ff;
   logic [rlsd_pkg::ANG_W-1:0]      gate_ff;
   logic                            prev_ff;
   logic [rlsd_pkg::ANG_W-1:0]      last_ff;

   logic [N-1:0]                    act_ff;
   logic [rlsd_pkg::OUTER_W-1:0]    outer_ff;
   logic                            contact_ff;
   logic [rlsd_pkg::IDX_W-1:0]      k_ff;
   logic [rlsd_pkg::STEP_W-1:0]     step_ff;
   logic [4:0]                      count_ff;
   logic signed [rlsd_pkg::ACC_W-1:0] rx_ff, ry_ff, vx_ff, vy_ff;
   logic [rlsd_pkg::RC_W-1:0]       rc_ff;
   logic [rlsd_pkg::RUNS_W-1:0]     runs_ff;
   logic signed [rlsd_pkg::CX_W-1:0] cx_ff, cy_ff;
   logic signed [rlsd_pkg::CZ_W-1:0] cz_ff;
   logic [rlsd_pkg::ITER_W-1:0]     iter_ff;
   logic [rlsd_pkg::PROD_W-1:0]     prod_ff;
   logic [rlsd_pkg::DIV_W-1:0]      len_ff;
   logic [15:0]                     dist_ff;

   logic                            rsp_valid_ff;
   logic                            o_contact_ff;
   logic [4:0]                      o_count_ff;
   logic [3:0]                      o_outer_ff;
   logic [3:0]                      o_runs_ff;
   logic [15:0]                     o_dir_ff;
   logic [15:0]                     o_dist_ff;

   logic [rlsd_pkg::SENSOR_W-1:0]   s_w;
   logic                            contact_w, inner_any, req_fire, slot_free;
   logic [rlsd_pkg::IDX_W-1:0]      p_w, kstart_w;
   logic signed [rlsd_pkg::UV_W-1:0] ux_w, uy_w;
   logic [rlsd_pkg::ACC_W-1:0]      rx_mag, ry_mag;
   logic [rlsd_pkg::DIV_W-1:0]      div_num;
   logic [rlsd_pkg::RC_W-1:0]       div_den;
   logic                            div_start, div_done;
   logic [rlsd_pkg::DIV_W-1:0]      div_q;
   logic signed [rlsd_pkg::ACC_W-1:0] q_s;
   logic signed [rlsd_pkg::CX_W-1:0] vx16, vy16, xs, ys;
   logic [rlsd_pkg::PROD_W:0]       len_sum;
   logic [rlsd_pkg::ANG_W-1:0]      dir_w, diff_w, dir_out;
   logic signed [rlsd_pkg::ANG_W+1:0] d18, g18;

   assign s_w       = req_ch.sensor_bits & ~mask_ff;
   assign contact_w = |s_w[N+rlsd_pkg::OUTER_W-1:0];
   assign inner_any = |s_w[N-1:0];
   assign req_fire  = req_ch.valid && req_ch.ready;
   assign slot_free = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      p_w = '0;
      for (int k = N - 1; k >= 0; k--) begin
         if (!s_w[k]) p_w = rlsd_pkg::IDX_W'(k);
      end
      kstart_w = (p_w == rlsd_pkg::IDX_W'(N - 1)) ? '0 : p_w + rlsd_pkg::IDX_W'(1);
   end

   assign ux_w   = rlsd_pkg::UX_TABLE[k_ff*rlsd_pkg::UV_W +: rlsd_pkg::UV_W];
   assign uy_w   = rlsd_pkg::UY_TABLE[k_ff*rlsd_pkg::UV_W +: rlsd_pkg::UV_W];
   assign rx_mag = rx_ff[rlsd_pkg::ACC_W-1] ? -rx_ff : rx_ff;
   assign ry_mag = ry_ff[rlsd_pkg::ACC_W-1] ? -ry_ff : ry_ff;
   assign q_s    = $signed({1'b0, div_q[rlsd_pkg::ACC_W-2:0]});
   assign vx16   = {{(rlsd_pkg::CX_W-rlsd_pkg::ACC_W-4){vx_ff[rlsd_pkg::ACC_W-1]}}, vx_ff, 4'b0};
   assign vy16   = {{(rlsd_pkg::CX_W-rlsd_pkg::ACC_W-4){vy_ff[rlsd_pkg::ACC_W-1]}}, vy_ff, 4'b0};
   assign xs     = cx_ff >>> iter_ff;
   assign ys     = cy_ff >>> iter_ff;
   assign len_sum = {1'b0, prod_ff} + (rlsd_pkg::PROD_W+1)'(524288);

   assign dir_w  = rlsd_pkg::ANG_W'(0) - cz_ff[rlsd_pkg::ANG_W-1:0];
   assign diff_w = dir_w - last_ff;
   assign d18    = $signed({{2{diff_w[rlsd_pkg::ANG_W-1]}}, diff_w});
   assign g18    = $signed({2'b0, gate_ff});
   always_comb begin
      if (!contact_ff) dir_out = last_ff;
      else if (prev_ff && !((d18 > -g18) && (d18 < g18))) dir_out = last_ff;
      else dir_out = dir_w;
   end

   rlsd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .done     (div_done),
      .quotient (div_q)
   );

   always_ff @(posedge clock) begin
      if (reset) state_ff <= rlsd_pkg::ST_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in  = state_ff;
      div_start = 1'b0;
      div_num   = rx_mag + rlsd_pkg::DIV_W'(rc_ff >> 1);
      div_den   = rc_ff;
      unique case (state_ff)
         rlsd_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (!contact_w) state_in = rlsd_pkg::ST_FIN;
               else if (inner_any) state_in = rlsd_pkg::ST_SCAN;
               else state_in = rlsd_pkg::ST_VEC_INIT;
            end
         end
         rlsd_pkg::ST_SCAN: begin
            if (step_ff == '0) begin
               if (rc_ff != '0) begin
                  div_start = 1'b1;
                  state_in  = rlsd_pkg::ST_DIV_X;
               end else begin
                  state_in = rlsd_pkg::ST_VEC_INIT;
               end
            end else if (!act_ff[k_ff] && rc_ff != '0) begin
               div_start = 1'b1;
               state_in  = rlsd_pkg::ST_DIV_X;
            end
         end
         rlsd_pkg::ST_DIV_X: begin
            div_num = ry_mag + rlsd_pkg::DIV_W'(rc_ff >> 1);
            if (div_done) begin
               div_start = 1'b1;
               state_in  = rlsd_pkg::ST_DIV_Y;
            end
         end
         rlsd_pkg::ST_DIV_Y: begin
            if (div_done) state_in = rlsd_pkg::ST_SCAN;
         end
         rlsd_pkg::ST_VEC_INIT: begin
            if (vx_ff == '0 && vy_ff == '0) state_in = rlsd_pkg::ST_MUL;
            else state_in = rlsd_pkg::ST_VEC;
         end
         rlsd_pkg::ST_VEC: begin
            if (iter_ff == rlsd_pkg::ITER_W'(rlsd_pkg::CORDIC_STEPS - 1))
               state_in = rlsd_pkg::ST_MUL;
         end
         rlsd_pkg::ST_MUL: state_in = rlsd_pkg::ST_LEN;
         rlsd_pkg::ST_LEN: state_in = rlsd_pkg::ST_DIST;
         rlsd_pkg::ST_DIST: begin
            div_num = len_ff + rlsd_pkg::DIV_W'(runs_ff >> 1);
            div_den = {1'b0, runs_ff};
            if (runs_ff == '0) begin
               state_in = rlsd_pkg::ST_FIN;
            end else begin
               div_start = 1'b1;
               state_in  = rlsd_pkg::ST_DIV_D;
            end
         end
         rlsd_pkg::ST_DIV_D: begin
            if (div_done) state_in = rlsd_pkg::ST_FIN;
         end
         rlsd_pkg::ST_FIN: begin
            if (slot_free) state_in = rlsd_pkg::ST_IDLE;
         end
         default: state_in = rlsd_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff      <= rlsd_pkg::MASK_RESET;
         gate_ff      <= rlsd_pkg::GATE_RESET;
         prev_ff      <= 1'b0;
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_ch.valid) begin
            if (csr_ch.index == rlsd_pkg::REG_MASK)
               mask_ff <= csr_ch.data[rlsd_pkg::SENSOR_W-1:0];
            else if (csr_ch.index == rlsd_pkg::REG_GATE)
               gate_ff <= csr_ch.data[rlsd_pkg::ANG_W-1:0];
         end
         if (state_ff == rlsd_pkg::ST_FIN && slot_free) begin
            rsp_valid_ff <= 1'b1;
            prev_ff      <= contact_ff;
            last_ff      <= dir_out;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         rlsd_pkg::ST_IDLE: begin
            if (req_fire) begin
               act_ff     <= s_w[N-1:0];
               outer_ff   <= s_w[N+rlsd_pkg::OUTER_W-1:N];
               contact_ff <= contact_w;
               k_ff       <= kstart_w;
               step_ff    <= rlsd_pkg::STEP_W'(N);
               count_ff   <= '0;
               rx_ff      <= '0;
               ry_ff      <= '0;
               rc_ff      <= '0;
               runs_ff    <= '0;
               dist_ff    <= '0;
               cz_ff      <= '0;
               if (inner_any) begin
                  vx_ff <= '0;
                  vy_ff <= '0;
               end else begin
                  if (s_w[N+2])      vx_ff <= -rlsd_pkg::Q12_ONE;
                  else if (s_w[N])   vx_ff <= rlsd_pkg::Q12_ONE;
                  else               vx_ff <= '0;
                  if (s_w[N+3])      vy_ff <= -rlsd_pkg::Q12_ONE;
                  else if (s_w[N+1]) vy_ff <= rlsd_pkg::Q12_ONE;
                  else               vy_ff <= '0;
               end
            end
         end
         rlsd_pkg::ST_SCAN: begin
            if (step_ff != '0) begin
               step_ff  <= step_ff - rlsd_pkg::STEP_W'(1);
               k_ff     <= (k_ff == rlsd_pkg::IDX_W'(N - 1)) ? '0 : k_ff + rlsd_pkg::IDX_W'(1);
               count_ff <= count_ff + 5'(act_ff[k_ff]);
               if (act_ff[k_ff]) begin
                  rx_ff <= rx_ff + {{(rlsd_pkg::ACC_W-rlsd_pkg::UV_W){ux_w[rlsd_pkg::UV_W-1]}}, ux_w};
                  ry_ff <= ry_ff + {{(rlsd_pkg::ACC_W-rlsd_pkg::UV_W){uy_w[rlsd_pkg::UV_W-1]}}, uy_w};
                  rc_ff <= rc_ff + rlsd_pkg::RC_W'(1);
               end
            end
         end
         rlsd_pkg::ST_DIV_X: begin
            if (div_done) vx_ff <= rx_ff[rlsd_pkg::ACC_W-1] ? vx_ff - q_s : vx_ff + q_s;
         end
         rlsd_pkg::ST_DIV_Y: begin
            if (div_done) begin
               vy_ff   <= ry_ff[rlsd_pkg::ACC_W-1] ? vy_ff - q_s : vy_ff + q_s;
               rx_ff   <= '0;
               ry_ff   <= '0;
               rc_ff   <= '0;
               runs_ff <= runs_ff + rlsd_pkg::RUNS_W'(1);
            end
         end
         rlsd_pkg::ST_VEC_INIT: begin
            iter_ff <= '0;
            if (vx_ff == '0 && vy_ff == '0) begin
               cx_ff <= '0;
               cy_ff <= '0;
               cz_ff <= '0;
            end else if (vx_ff[rlsd_pkg::ACC_W-1]) begin
               cx_ff <= -vx16;
               cy_ff <= -vy16;
               cz_ff <= rlsd_pkg::CZ_W'(32768);
            end else begin
               cx_ff <= vx16;
               cy_ff <= vy16;
               cz_ff <= '0;
            end
         end
         rlsd_pkg::ST_VEC: begin
            iter_ff <= iter_ff + rlsd_pkg::ITER_W'(1);
            if (cy_ff > 0) begin
               cx_ff <= cx_ff + ys;
               cy_ff <= cy_ff - xs;
               cz_ff <= cz_ff + $signed({4'b0, rlsd_pkg::atan_unit(iter_ff)});
            end else begin
               cx_ff <= cx_ff - ys;
               cy_ff <= cy_ff + xs;
               cz_ff <= cz_ff - $signed({4'b0, rlsd_pkg::atan_unit(iter_ff)});
            end
         end
         rlsd_pkg::ST_MUL: prod_ff <= cx_ff[rlsd_pkg::CX_W-2:0] * rlsd_pkg::LEN_GAIN;
         rlsd_pkg::ST_LEN: len_ff <= len_sum[20 +: rlsd_pkg::DIV_W];
         rlsd_pkg::ST_DIST: begin
            if (runs_ff == '0) dist_ff <= 16'hFFFF;
         end
         rlsd_pkg::ST_DIV_D: begin
            if (div_done) dist_ff <= (div_q > rlsd_pkg::DIV_W'(16'hFFFF)) ? 16'hFFFF : div_q[15:0];
         end
         rlsd_pkg::ST_FIN: begin
            if (slot_free) begin
               o_contact_ff <= contact_ff;
               o_count_ff   <= count_ff;
               o_outer_ff   <= outer_ff;
               o_runs_ff    <= runs_ff;
               o_dir_ff     <= dir_out;
               o_dist_ff    <= contact_ff ? dist_ff : '0;
            end
         end
         default: ;
      endcase
   end

   assign req_ch.ready              = state_ff == rlsd_pkg::ST_IDLE;
   assign csr_ch.ready              = 1'b1;
   assign rsp_ch.valid              = rsp_valid_ff;
   assign rsp_ch.contact            = o_contact_ff;
   assign rsp_ch.inner_active_count = o_count_ff;
   assign rsp_ch.outer_flags        = o_outer_ff;
   assign rsp_ch.run_count          = o_runs_ff;
   assign rsp_ch.direction          = $signed(o_dir_ff);
   assign rsp_ch.distance           = o_dist_ff;
endmodule

>>> rtl/rlsd_div.sv
// ----------------------------------------------------------------------------
// rlsd_div
// Restoring divider, one quotient bit per cycle, small divisor.
// ----------------------------------------------------------------------------
module rlsd_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [rlsd_pkg::DIV_W-1:0]   dividend,
   input  logic [rlsd_pkg::RC_W-1:0]    divisor,
   output logic                         done,
   output logic [rlsd_pkg::DIV_W-1:0]   quotient
);
   localparam int CNT_W = $clog2(rlsd_pkg::DIV_W + 1);

   logic [rlsd_pkg::DIV_W-1:0] quo_ff;
   logic [rlsd_pkg::RC_W-1:0]  rem_ff;
   logic [rlsd_pkg::RC_W-1:0]  dsr_ff;
   logic [CNT_W-1:0]           cnt_ff;
   logic                       done_ff;
   logic [rlsd_pkg::RC_W:0]    rem_sh;
   logic [rlsd_pkg::RC_W:0]    rem_sub;
   logic                       ge;

   always_comb begin
      rem_sh  = {rem_ff, quo_ff[rlsd_pkg::DIV_W-1]};
      ge      = rem_sh >= {1'b0, dsr_ff};
      rem_sub = ge ? rem_sh - {1'b0, dsr_ff} : rem_sh;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= cnt_ff == CNT_W'(1);
         if (start) begin
            quo_ff <= dividend;
            rem_ff <= '0;
            dsr_ff <= divisor;
            cnt_ff <= CNT_W'(rlsd_pkg::DIV_W);
         end else if (cnt_ff != '0) begin
            quo_ff <= {quo_ff[rlsd_pkg::DIV_W-2:0], ge};
            rem_ff <= rem_sub[rlsd_pkg::RC_W-1:0];
            cnt_ff <= cnt_ff - CNT_W'(1);
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule
